### rtl/scft_pkg.sv
// shared types, constants and functions of the sentence crc16 trailer framer
`default_nettype none
package scft_pkg;

  // crc-16 constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // skip counter
  localparam logic [1:0]  SKIP_RESET = 2'd2;
  localparam logic [1:0]  SEEN_MAX   = 2'd3;

  // trailer characters
  localparam logic [7:0]  CHAR_STAR    = 8'h2A;
  localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // back-end output phase codes
  localparam int          PH_W    = 3;
  localparam logic [2:0]  PH_BYTE = 3'd0;
  localparam logic [2:0]  PH_STAR = 3'd1;
  localparam logic [2:0]  PH_HEX3 = 3'd2;
  localparam logic [2:0]  PH_HEX2 = 3'd3;
  localparam logic [2:0]  PH_HEX1 = 3'd4;
  localparam logic [2:0]  PH_HEX0 = 3'd5;
  localparam logic [2:0]  PH_NL   = 3'd6;

  // one classified byte as it waits in the queue
  typedef struct packed {
    logic [7:0]  data;
    logic        sentence_end;
    logic [15:0] crc;
  } entry_t;

  // push side of the queue
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  // pop side of the queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // fold one byte into the crc, msb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // uppercase hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) ch = 8'h30 + {4'h0, n};
    else           ch = 8'h37 + {4'h0, n};
    return ch;
  endfunction

endpackage
`default_nettype wire

### rtl/scft_front.sv
// front end: accepts bytes, applies the skip rule and runs the crc
`default_nettype none
module scft_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_skip_count,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_sentence_end,
  input  wire logic                  q_full,
  output scft_pkg::push_t            q_push
);

  logic [1:0]  skip_r;
  logic [1:0]  seen_r, seen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_fold_val;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // crc after this byte, or unchanged when the byte is skipped
  always_comb begin
    if (seen_r < skip_r) crc_fold_val = crc_r;
    else                 crc_fold_val = scft_pkg::crc_fold(crc_r, in_data_byte);
  end

  // next sentence state
  always_comb begin
    crc_nxt  = crc_r;
    seen_nxt = seen_r;
    if (accept) begin
      if (in_sentence_end) begin
        crc_nxt  = scft_pkg::CRC_INIT;
        seen_nxt = '0;
      end else begin
        crc_nxt = crc_fold_val;
        if (seen_r != scft_pkg::SEEN_MAX) seen_nxt = seen_r + 2'd1;
      end
    end
  end

  // classified transaction into the queue
  always_comb begin
    q_push.push               = accept;
    q_push.entry.data         = in_data_byte;
    q_push.entry.sentence_end = in_sentence_end;
    q_push.entry.crc          = crc_fold_val;
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= scft_pkg::SKIP_RESET;
      seen_r <= '0;
      crc_r  <= scft_pkg::CRC_INIT;
    end else begin
      if (cfg_we) skip_r <= cfg_skip_count;
      seen_r <= seen_nxt;
      crc_r  <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/scft_queue.sv
// short fifo between the front and back ends
`default_nettype none
module scft_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire scft_pkg::push_t q_push,
  input  wire logic            pop,
  output logic                 full,
  output scft_pkg::head_t      head
);

  scft_pkg::entry_t              mem_r [scft_pkg::QDEPTH];
  logic [scft_pkg::QAW-1:0]      wptr_r, rptr_r;
  logic [scft_pkg::QCW-1:0]      count_r;
  logic                          do_pop;

  assign full       = (count_r == scft_pkg::QCW'(scft_pkg::QDEPTH));
  assign do_pop     = pop && head.valid;

  // oldest entry
  always_comb begin
    head.valid = (count_r != '0);
    head.entry = mem_r[rptr_r];
  end

  // storage
  always_ff @(posedge clk) begin
    if (q_push.push) mem_r[wptr_r] <= q_push.entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (q_push.push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)      rptr_r <= rptr_r + 1'b1;
      if (q_push.push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !q_push.push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/scft_back.sv
// back end: emits each byte and the trailer after a final byte
`default_nettype none
module scft_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire scft_pkg::head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [scft_pkg::PH_W-1:0] phase_r, phase_nxt;
  logic                      out_accept;

  assign out_valid  = head.valid;
  assign out_accept = out_valid && out_ready;
  assign out_last   = (phase_r == scft_pkg::PH_NL);

  // output character for the current phase
  always_comb begin
    case (phase_r)
      scft_pkg::PH_BYTE: out_byte = head.entry.data;
      scft_pkg::PH_STAR: out_byte = scft_pkg::CHAR_STAR;
      scft_pkg::PH_HEX3: out_byte = scft_pkg::hex_char(head.entry.crc[15:12]);
      scft_pkg::PH_HEX2: out_byte = scft_pkg::hex_char(head.entry.crc[11:8]);
      scft_pkg::PH_HEX1: out_byte = scft_pkg::hex_char(head.entry.crc[7:4]);
      scft_pkg::PH_HEX0: out_byte = scft_pkg::hex_char(head.entry.crc[3:0]);
      scft_pkg::PH_NL:   out_byte = scft_pkg::CHAR_NEWLINE;
      default:           out_byte = head.entry.data;
    endcase
  end

  // phase sequencing and queue pop
  always_comb begin
    phase_nxt = phase_r;
    pop       = 1'b0;
    if (out_accept) begin
      if (phase_r == scft_pkg::PH_BYTE && !head.entry.sentence_end) begin
        pop = 1'b1;
      end else if (phase_r == scft_pkg::PH_NL) begin
        pop       = 1'b1;
        phase_nxt = scft_pkg::PH_BYTE;
      end else begin
        phase_nxt = phase_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= scft_pkg::PH_BYTE;
    else        phase_r <= phase_nxt;
  end

endmodule
`default_nettype wire

### rtl/sentence_crc16_trailer_framer_top.sv
// top level of the sentence crc16 trailer framer
// Takes one sentence byte per transaction and passes it on, folding every byte
// after the first cfg_skip_count bytes into a CRC-16 (poly 0x1021, init 0xFFFF);
// after a byte flagged with in_sentence_end it appends '*', four uppercase hex
// digits and a newline flagged with out_last. The front end accepts one byte per
// cycle while the queue is not full, with the CRC update done in that cycle; a
// four-entry queue decouples it from the back end, which sends one character
// per cycle while out_ready is high, so a final byte becomes seven output
// characters. Sustained rate is set by the output side: a sentence of N bytes
// comes out as N + 6 characters. Write cfg_skip_count only while idle.
`default_nettype none
module sentence_crc16_trailer_framer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_skip_count,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_sentence_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  scft_pkg::push_t q_push;
  scft_pkg::head_t head;
  logic            q_full;
  logic            pop;

  // classification and crc
  scft_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_skip_count  (cfg_skip_count),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_sentence_end (in_sentence_end),
    .q_full          (q_full),
    .q_push          (q_push)
  );

  // decoupling queue
  scft_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .full   (q_full),
    .head   (head)
  );

  // character output
  scft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

### rtl/scft_checker.sv
// port-level checker for the sentence crc16 trailer framer, bound to the top level
`default_nettype none
module scft_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed while stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the last character is always the newline
  a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte == scft_pkg::CHAR_NEWLINE)
    else $error("last flag on a character other than newline");

  // input back-pressure only when the queue holds work
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing to send");

endmodule

bind sentence_crc16_trailer_framer_top scft_checker u_scft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
`default_nettype wire
